### design/crcsw_pkg.sv
// Shared types, codes and the CRC-8 division step for the stop-and-wait receiver.
// No dependencies; imported by every module of the block.
package crcsw_pkg;

  // Verdict codes
  localparam logic [3:0] ACK_SEQ_ONE  = 4'd6;
  localparam logic [3:0] ACK_SEQ_ZERO = 4'd7;
  localparam logic [3:0] NAK_CODE     = 4'd15;

  // Polynomial after reset: x^8 + x^2 + x + 1
  localparam logic [7:0] CRC_POLY_RESET = 8'h07;

  // Position within the frame, saturating at the body code
  localparam logic [1:0] POS_FLAG   = 2'd0;
  localparam logic [1:0] POS_HEADER = 2'd1;
  localparam logic [1:0] POS_FIRST  = 2'd2;
  localparam logic [1:0] POS_BODY   = 2'd3;

  // Command passed from the front end to the back end
  typedef struct packed {
    logic       verdict;    // 1 frame verdict, 0 payload byte release
    logic [7:0] data;       // released payload byte
    logic       crc_ok;     // remainder zero and frame long enough
    logic       dup;        // accepted frame already seen
    logic       short_frm;  // fewer than four bytes
    logic       seq;        // sequence bit from the header
  } cmd_t;

  // Shift one byte MSB first through the degree-8 long division
  function automatic logic [7:0] crc8_step(input logic [7:0] rem,
                                           input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] r;
    logic       top;
    r = rem;
    for (int b = 7; b >= 0; b--) begin
      top = r[7];
      r   = {r[6:0], data[b]};
      if (top) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

endpackage

### design/crcsw_front.sv
// Front end: tracks frame position, CRC remainder and sequence bits, and
// classifies each accepted item into a command. Depends on crcsw_pkg.
module crcsw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [7:0]          in_data_byte,
  input  logic                in_end_of_frame,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  output logic                push,
  output crcsw_pkg::cmd_t     push_cmd
);
  import crcsw_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [7:0] held_r, held_nxt;
  logic       holding_r, holding_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic       frame_seq_r, frame_seq_nxt;
  logic       expected_seq_r, expected_seq_nxt;
  logic [7:0] poly_r;
  logic       is_short;
  logic       frame_ok;
  logic       seq_differs;

  // Classify the frame on its closing flag
  assign is_short    = (pos_r != POS_BODY);
  assign frame_ok    = !is_short && (rem_r == 8'd0);
  assign seq_differs = (frame_seq_r != expected_seq_r);

  // Advance frame state and build the command
  always_comb begin
    pos_nxt          = pos_r;
    held_nxt         = held_r;
    holding_nxt      = holding_r;
    rem_nxt          = rem_r;
    frame_seq_nxt    = frame_seq_r;
    expected_seq_nxt = expected_seq_r;
    push             = 1'b0;
    push_cmd         = '0;
    if (in_accept) begin
      if (in_end_of_frame) begin
        push               = 1'b1;
        push_cmd.verdict   = 1'b1;
        push_cmd.crc_ok    = frame_ok;
        push_cmd.dup       = frame_ok && seq_differs;
        push_cmd.short_frm = is_short;
        push_cmd.seq       = frame_seq_r;
        if (frame_ok && !seq_differs) begin
          expected_seq_nxt = ~expected_seq_r;
        end
        pos_nxt     = POS_FLAG;
        holding_nxt = 1'b0;
        held_nxt    = 8'd0;
        rem_nxt     = 8'd0;
      end else begin
        unique case (pos_r)
          POS_FLAG: begin
            pos_nxt = POS_HEADER;
          end
          POS_HEADER: begin
            frame_seq_nxt = in_data_byte[7];
            pos_nxt       = POS_FIRST;
          end
          default: begin
            pos_nxt     = POS_BODY;
            rem_nxt     = crc8_step(rem_r, in_data_byte, poly_r);
            held_nxt    = in_data_byte;
            holding_nxt = 1'b1;
            if (holding_r) begin
              push          = 1'b1;
              push_cmd.data = held_r;
            end
          end
        endcase
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= POS_FLAG;
      holding_r      <= 1'b0;
      rem_r          <= 8'd0;
      frame_seq_r    <= 1'b0;
      expected_seq_r <= 1'b0;
    end else begin
      pos_r          <= pos_nxt;
      holding_r      <= holding_nxt;
      rem_r          <= rem_nxt;
      frame_seq_r    <= frame_seq_nxt;
      expected_seq_r <= expected_seq_nxt;
    end
  end

  // Payload byte waiting for release
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  // Polynomial register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= CRC_POLY_RESET;
    end else if (cfg_wr_en) begin
      poly_r <= cfg_wr_data;
    end
  end

  // A closing flag always leaves the frame state clear
  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_end_of_frame |=> pos_r == POS_FLAG && !holding_r && rem_r == 8'd0)
    else $error("frame state not cleared after closing flag");

  // The expected bit only moves on a verdict
  a_seq_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_accept && in_end_of_frame) |=> expected_seq_r == $past(expected_seq_r))
    else $error("expected sequence bit changed outside a verdict");

endmodule

### design/crcsw_queue.sv
// Short command queue between front and back end.
// Depends on crcsw_pkg for the command type.
module crcsw_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  crcsw_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output crcsw_pkg::cmd_t pop_cmd,
  output logic            empty
);
  import crcsw_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == DEPTH_CNT);
  assign empty   = (count_r == '0);
  assign pop_cmd = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("command pushed into full queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue occupancy lost a push");

endmodule

### design/crcsw_back.sv
// Back end: turns queued commands into result fields and holds them in the
// output register until taken. Depends on crcsw_pkg.
module crcsw_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_empty,
  input  crcsw_pkg::cmd_t cmd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_kind,
  output logic [7:0]      out_payload_byte,
  output logic [3:0]      out_ack_code,
  output logic            out_crc_ok,
  output logic            out_is_duplicate,
  output logic            out_frame_short
);
  import crcsw_pkg::*;

  logic       valid_r;
  logic       kind_r, kind_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [3:0] ack_r, ack_nxt;
  logic       crc_ok_r, crc_ok_nxt;
  logic       dup_r, dup_nxt;
  logic       short_r, short_nxt;

  // Take a command when the output register is free or being drained
  assign pop = !cmd_empty && (!valid_r || !out_stall);

  // Format the result fields
  always_comb begin
    kind_nxt   = cmd.verdict;
    byte_nxt   = cmd.verdict ? 8'd0 : cmd.data;
    crc_ok_nxt = cmd.verdict && cmd.crc_ok;
    dup_nxt    = cmd.verdict && cmd.crc_ok && cmd.dup;
    short_nxt  = cmd.verdict && cmd.short_frm;
    if (!cmd.verdict) begin
      ack_nxt = 4'd0;
    end else if (!cmd.crc_ok) begin
      ack_nxt = NAK_CODE;
    end else begin
      ack_nxt = cmd.seq ? ACK_SEQ_ONE : ACK_SEQ_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r   <= kind_nxt;
      byte_r   <= byte_nxt;
      ack_r    <= ack_nxt;
      crc_ok_r <= crc_ok_nxt;
      dup_r    <= dup_nxt;
      short_r  <= short_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = byte_r;
  assign out_ack_code     = ack_r;
  assign out_crc_ok       = crc_ok_r;
  assign out_is_duplicate = dup_r;
  assign out_frame_short  = short_r;

endmodule

### design/crc_checked_stop_and_wait_receiver_core.sv
// Top level of the CRC-8 checked stop-and-wait receiver.
// Depends on crcsw_pkg, crcsw_front, crcsw_queue and crcsw_back.
//
//   channel  | direction | handshake           | payload
//   in_      | input     | in_valid/in_stall   | data_byte, end_of_frame
//   out_     | output    | out_valid/out_stall | kind, payload_byte, ack_code,
//            |           |                     | crc_ok, is_duplicate, frame_short
//   cfg_     | input     | cfg_wr_en           | cfg_wr_data (polynomial)
//
// One item per cycle while in_stall is low; a result is registered first in the command
// queue and then in the output register.
// The unrolled CRC-8 division step in the front end sets the cycle time.
// rst_n is synchronous: polynomial back to 0x07, frame and sequence state cleared.
// in_stall rises only while the command queue is full, which needs out_stall held.
module crc_checked_stop_and_wait_receiver_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_frame,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_payload_byte,
  output logic [3:0] out_ack_code,
  output logic       out_crc_ok,
  output logic       out_is_duplicate,
  output logic       out_frame_short,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import crcsw_pkg::*;

  logic in_accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t pop_cmd;
  logic q_empty;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  crcsw_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_accept       (in_accept),
    .in_data_byte    (in_data_byte),
    .in_end_of_frame (in_end_of_frame),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  crcsw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  crcsw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_empty        (q_empty),
    .cmd              (pop_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_ack_code     (out_ack_code),
    .out_crc_ok       (out_crc_ok),
    .out_is_duplicate (out_is_duplicate),
    .out_frame_short  (out_frame_short)
  );

endmodule

### tb/sv/tb.sv
// Self-checking bench for crc_checked_stop_and_wait_receiver_core: frames in, payload and verdicts out.
// Depends on crcsw_pkg for the verdict codes, position codes and reset polynomial.
module tb;
  import crcsw_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       eof;
  } link_byte_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    logic [3:0] ack;
    logic       crc_ok;
    logic       dup;
    logic       short_frm;
  } rx_outcome_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_end_of_frame = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_payload_byte;
  logic [3:0] out_ack_code;
  logic       out_crc_ok;
  logic       out_is_duplicate;
  logic       out_frame_short;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  link_byte_t  byte_feed[$];
  rx_outcome_t rx_outcomes[$];
  int          fault_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  // Receiver state as the predictor tracks it
  logic [1:0] rx_pos = POS_FLAG;
  logic [7:0] rx_held = 8'h00;
  logic       rx_holding = 1'b0;
  logic [7:0] rx_rem = 8'h00;
  logic       rx_seq = 1'b0;
  logic       rx_want = 1'b0;
  logic [7:0] rx_poly = CRC_POLY_RESET;

  // Sender-side view used when building frames
  logic       gen_seq = 1'b0;
  logic [7:0] gen_poly = CRC_POLY_RESET;

  crc_checked_stop_and_wait_receiver_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_frame  (in_end_of_frame),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_ack_code     (out_ack_code),
    .out_crc_ok       (out_crc_ok),
    .out_is_duplicate (out_is_duplicate),
    .out_frame_short  (out_frame_short),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Long division of one byte, MSB first, by x^8 + poly
  function automatic logic [7:0] crc8_shift(input logic [7:0] rem, input logic [7:0] b,
                                            input logic [7:0] poly);
    logic [7:0] r;
    logic       msb;
    r = rem;
    for (int i = 7; i >= 0; i--) begin
      msb = r[7];
      r = {r[6:0], b[i]};
      if (msb) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  // Advance the receiver by one accepted byte and queue what it gives out
  task automatic receive_byte(input logic [7:0] b, input logic eof);
    rx_outcome_t r;
    r = '0;
    if (eof) begin
      r.kind = 1'b1;
      r.short_frm = (rx_pos != POS_BODY);
      if (!r.short_frm && rx_rem == 8'h00) begin
        r.crc_ok = 1'b1;
        r.dup = (rx_seq != rx_want);
        r.ack = rx_seq ? ACK_SEQ_ONE : ACK_SEQ_ZERO;
        if (!r.dup) begin
          rx_want = ~rx_want;
        end
      end else begin
        r.ack = NAK_CODE;
      end
      rx_outcomes.push_back(r);
      rx_pos = POS_FLAG;
      rx_held = 8'h00;
      rx_holding = 1'b0;
      rx_rem = 8'h00;
    end else begin
      case (rx_pos)
        POS_FLAG: begin
          rx_pos = POS_HEADER;
        end
        POS_HEADER: begin
          rx_seq = b[7];
          rx_pos = POS_FIRST;
        end
        default: begin
          rx_pos = POS_BODY;
          rx_rem = crc8_shift(rx_rem, b, rx_poly);
          // release the byte held from the previous step
          if (rx_holding) begin
            r.payload = rx_held;
            rx_outcomes.push_back(r);
          end
          rx_held = b;
          rx_holding = 1'b1;
        end
      endcase
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic eof);
    link_byte_t item;
    item.data = b;
    item.eof = eof;
    byte_feed.push_back(item);
  endtask

  // Build a whole frame; extremes alternates 0xFF and 0x00 in the payload
  task automatic queue_frame(input logic seq, input int npay, input bit bad_crc,
                             input bit extremes);
    logic [7:0] rem;
    logic [7:0] b;
    rem = 8'h00;
    push_byte(($urandom_range(0, 1) == 0) ? 8'h7E : 8'($urandom), 1'b0);
    push_byte({seq, 7'($urandom)}, 1'b0);
    for (int i = 0; i < npay; i++) begin
      b = extremes ? ((i % 2 == 0) ? 8'hFF : 8'h00) : 8'($urandom);
      rem = crc8_shift(rem, b, gen_poly);
      push_byte(b, 1'b0);
    end
    // check byte that clears the remainder, spoilt on request
    b = crc8_shift(rem, 8'h00, gen_poly);
    if (bad_crc) begin
      b = b ^ 8'($urandom_range(1, 255));
    end
    push_byte(b, 1'b0);
    push_byte(($urandom_range(0, 1) == 0) ? 8'h7E : 8'($urandom), 1'b1);
  endtask

  // Closing mark after n - 1 ordinary bytes, or after a run of noise
  task automatic queue_cut(input int n);
    for (int i = 1; i < n; i++) begin
      push_byte(8'($urandom), 1'b0);
    end
    push_byte(8'($urandom), 1'b1);
  endtask

  task automatic queue_random_frame();
    int pick;
    int npay;
    pick = $urandom_range(0, 99);
    npay = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
    if (pick < 65) begin
      queue_frame(gen_seq, npay, 1'b0, 1'b0);
      gen_seq = ~gen_seq;
    end else if (pick < 75) begin
      queue_frame(~gen_seq, npay, 1'b0, 1'b0);
    end else if (pick < 87) begin
      queue_frame(1'($urandom), npay, 1'b1, 1'b0);
    end else if (pick < 94) begin
      queue_cut($urandom_range(1, 3));
    end else begin
      queue_cut($urandom_range(1, 9));
    end
  endtask

  // Hold until nothing is in flight, then let the pipeline settle
  task automatic wait_idle();
    while (byte_feed.size() != 0 || in_valid || rx_outcomes.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_poly(input logic [7:0] p);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rx_poly = p;
    gen_poly = p;
  endtask

  task automatic note_fault(input string msg);
    if (fault_count < 10) begin
      $display("%s", msg);
    end
    fault_count++;
  endtask

  // Drive items from the feed queue, predicting each one as it is accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        receive_byte(in_data_byte, in_end_of_frame);
      end
      if (!in_valid || !in_stall) begin
        if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data_byte <= byte_feed[0].data;
          in_end_of_frame <= byte_feed[0].eof;
          byte_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    rx_outcome_t want;
    rx_outcome_t got;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_kind, out_payload_byte, out_ack_code, out_crc_ok, out_is_duplicate,
               out_frame_short};
        if (rx_outcomes.size() == 0) begin
          note_fault($sformatf("unexpected result kind=%0d byte=%h ack=%0d ok=%0d dup=%0d sh=%0d",
                               got.kind, got.payload, got.ack, got.crc_ok, got.dup,
                               got.short_frm));
        end else begin
          want = rx_outcomes.pop_front();
          if (got.kind != want.kind || got.payload != want.payload || got.ack != want.ack ||
              got.crc_ok != want.crc_ok || got.dup != want.dup ||
              got.short_frm != want.short_frm) begin
            note_fault($sformatf({"mismatch exp kind=%0d byte=%h ack=%0d ok=%0d dup=%0d sh=%0d",
                                  " got kind=%0d byte=%h ack=%0d ok=%0d dup=%0d sh=%0d"},
                                 want.kind, want.payload, want.ack, want.crc_ok, want.dup,
                                 want.short_frm, got.kind, got.payload, got.ack, got.crc_ok,
                                 got.dup, got.short_frm));
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Reset, directed frames, then random phases over a range of polynomials
  initial begin
    logic [7:0] polys[8];
    int         per_phase;
    int         queued;
    polys = '{8'h00, 8'hFF, 8'h07, 8'h31, 8'h1D, 8'h80, 8'h01, 8'h00};
    polys[7] = 8'($urandom);
    per_phase = 225;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short frames, both acks, a duplicate, a CRC error, extreme bytes
    queue_cut(1);
    queue_cut(2);
    queue_cut(3);
    queue_frame(1'b0, 2, 1'b0, 1'b1);
    queue_frame(1'b0, 0, 1'b0, 1'b0);
    queue_frame(1'b1, 1, 1'b1, 1'b0);
    queue_frame(1'b1, 1, 1'b0, 1'b0);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_poly(polys[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 79;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 79;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct = 8;
        end
      endcase
      queued = 0;
      while (queued < per_phase) begin
        queued -= byte_feed.size();
        queue_random_frame();
        queued += byte_feed.size();
        // keep the feed short so idling settings apply to what follows
        while (byte_feed.size() > 64) begin
          @(posedge clk);
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    fault_count += rx_outcomes.size();
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### crc_checked_stop_and_wait_receiver_core.f
design/crcsw_pkg.sv
design/crcsw_front.sv
design/crcsw_queue.sv
design/crcsw_back.sv
design/crc_checked_stop_and_wait_receiver_core.sv
tb/sv/tb.sv
